/* rtl/rc4sc_pkg.sv */
`default_nettype none

package rc4sc_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned PERM_DEPTH     = 256;
  localparam int unsigned KEY_BYTES_MAX  = 16;
  localparam int unsigned KEY_IDX_W      = 4;
  localparam int unsigned KEY_LEN_W      = 5;
  localparam int unsigned KEY_WORD_W     = 64;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd15;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 2'd2;

  // Datapath operation codes.
  localparam int unsigned OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_START    = 4'd1;
  localparam logic [OP_W-1:0] OP_INIT_WR  = 4'd2;
  localparam logic [OP_W-1:0] OP_KS_RD_A  = 4'd3;
  localparam logic [OP_W-1:0] OP_KS_RD_B  = 4'd4;
  localparam logic [OP_W-1:0] OP_KS_WR_A  = 4'd5;
  localparam logic [OP_W-1:0] OP_KS_WR_B  = 4'd6;
  localparam logic [OP_W-1:0] OP_GEN_RD_I = 4'd7;
  localparam logic [OP_W-1:0] OP_GEN_RD_J = 4'd8;
  localparam logic [OP_W-1:0] OP_GEN_WR_I = 4'd9;
  localparam logic [OP_W-1:0] OP_GEN_WR_J = 4'd10;
  localparam logic [OP_W-1:0] OP_GEN_RD_K = 4'd11;
  localparam logic [OP_W-1:0] OP_LOAD_OUT = 4'd12;

  typedef struct packed {
    logic            capture;
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* rtl/rc4sc_ram.sv */
`default_nettype none

module rc4sc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rc4sc_ctrl.sv */
`default_nettype none

module rc4sc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  input  wire logic              s_axis_tuser,
  output logic                   s_axis_tready,
  input  wire rc4sc_pkg::status_t status,
  output rc4sc_pkg::cmd_t        cmd
);

  import rc4sc_pkg::*;

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INIT    = 4'd1;
  localparam logic [3:0] ST_KS_RDA  = 4'd2;
  localparam logic [3:0] ST_KS_RDB  = 4'd3;
  localparam logic [3:0] ST_KS_WRA  = 4'd4;
  localparam logic [3:0] ST_KS_WRB  = 4'd5;
  localparam logic [3:0] ST_GEN_RDI = 4'd6;
  localparam logic [3:0] ST_GEN_RDJ = 4'd7;
  localparam logic [3:0] ST_GEN_WRI = 4'd8;
  localparam logic [3:0] ST_GEN_WRJ = 4'd9;
  localparam logic [3:0] ST_GEN_RDK = 4'd10;
  localparam logic [3:0] ST_GEN_OUT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.capture = 1'b1;
          if (s_axis_tuser) begin
            cmd.op     = OP_START;
            state_next = ST_INIT;
          end else begin
            state_next = ST_GEN_RDI;
          end
        end
      end
      ST_INIT: begin
        cmd.op = OP_INIT_WR;
        if (status.sweep_last) begin
          state_next = ST_KS_RDA;
        end
      end
      ST_KS_RDA: begin
        cmd.op     = OP_KS_RD_A;
        state_next = ST_KS_RDB;
      end
      ST_KS_RDB: begin
        cmd.op     = OP_KS_RD_B;
        state_next = ST_KS_WRA;
      end
      ST_KS_WRA: begin
        cmd.op     = OP_KS_WR_A;
        state_next = ST_KS_WRB;
      end
      ST_KS_WRB: begin
        cmd.op     = OP_KS_WR_B;
        state_next = status.sweep_last ? ST_GEN_RDI : ST_KS_RDA;
      end
      ST_GEN_RDI: begin
        cmd.op     = OP_GEN_RD_I;
        state_next = ST_GEN_RDJ;
      end
      ST_GEN_RDJ: begin
        cmd.op     = OP_GEN_RD_J;
        state_next = ST_GEN_WRI;
      end
      ST_GEN_WRI: begin
        cmd.op     = OP_GEN_WR_I;
        state_next = ST_GEN_WRJ;
      end
      ST_GEN_WRJ: begin
        cmd.op     = OP_GEN_WR_J;
        state_next = ST_GEN_RDK;
      end
      ST_GEN_RDK: begin
        cmd.op     = OP_GEN_RD_K;
        state_next = ST_GEN_OUT;
      end
      ST_GEN_OUT: begin
        // Wait here while the previous result still sits in the output register.
        if (status.out_free) begin
          cmd.op     = OP_LOAD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/rc4sc_datapath.sv */
`default_nettype none

module rc4sc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rc4sc_pkg::cmd_t                     cmd,
  output rc4sc_pkg::status_t                       status,
  input  wire logic [rc4sc_pkg::BYTE_W-1:0]        in_byte,
  input  wire logic                                cfg_valid,
  input  wire logic [rc4sc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rc4sc_pkg::KEY_WORD_W-1:0]    cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [rc4sc_pkg::BYTE_W-1:0]        out_byte
);

  import rc4sc_pkg::*;

  logic [KEY_LEN_W-1:0]  key_length;
  logic [KEY_WORD_W-1:0] key_low;
  logic [KEY_WORD_W-1:0] key_high;

  logic [BYTE_W-1:0]    a;
  logic [BYTE_W-1:0]    b;
  logic [KEY_IDX_W-1:0] kidx;
  logic [BYTE_W-1:0]    i;
  logic [BYTE_W-1:0]    j;

  logic [BYTE_W-1:0] text;
  logic [BYTE_W-1:0] hold_first;
  logic [BYTE_W-1:0] hold_second;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_q;

  logic [KEY_IDX_W-1:0]  kidx_last;
  logic [KEY_WORD_W-1:0] key_word;
  logic [BYTE_W-1:0]     key_byte;
  logic [BYTE_W-1:0]     b_sum;

  // Zero length acts as one byte; lengths above the key storage saturate.
  always_comb begin
    if (key_length == '0) begin
      kidx_last = '0;
    end else if (key_length > KEY_LEN_W'(KEY_BYTES_MAX)) begin
      kidx_last = KEY_IDX_W'(KEY_BYTES_MAX - 1);
    end else begin
      kidx_last = KEY_IDX_W'(key_length - KEY_LEN_W'(1));
    end
  end

  assign key_word = kidx[KEY_IDX_W-1] ? key_high : key_low;
  assign key_byte = key_word[{kidx[KEY_IDX_W-2:0], 3'b000} +: BYTE_W];
  assign b_sum    = b + ram_q + key_byte;

  assign status.sweep_last = (a == '1);
  assign status.out_free   = !out_valid || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (cmd.op)
      OP_INIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = a;
        ram_wdata = a;
      end
      OP_KS_RD_A: begin
        ram_re    = 1'b1;
        ram_raddr = a;
      end
      OP_KS_RD_B: begin
        ram_re    = 1'b1;
        ram_raddr = b_sum;
      end
      OP_KS_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = a;
        ram_wdata = ram_q;
      end
      OP_KS_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = b;
        ram_wdata = hold_first;
      end
      OP_GEN_RD_I: begin
        ram_re    = 1'b1;
        ram_raddr = i + BYTE_W'(1);
      end
      OP_GEN_RD_J: begin
        ram_re    = 1'b1;
        ram_raddr = j + ram_q;
      end
      OP_GEN_WR_I: begin
        ram_we    = 1'b1;
        ram_waddr = i;
        ram_wdata = ram_q;
      end
      OP_GEN_WR_J: begin
        ram_we    = 1'b1;
        ram_waddr = j;
        ram_wdata = hold_first;
      end
      OP_GEN_RD_K: begin
        ram_re    = 1'b1;
        ram_raddr = hold_first + hold_second;
      end
      default: begin
      end
    endcase
  end

  rc4sc_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PERM_DEPTH)
  ) u_perm (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
      key_low    <= '0;
      key_high   <= '0;
      a          <= '0;
      b          <= '0;
      kidx       <= '0;
      i          <= '0;
      j          <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_KEY_LENGTH: key_length <= cfg_data[KEY_LEN_W-1:0];
          REG_KEY_LOW:    key_low    <= cfg_data;
          REG_KEY_HIGH:   key_high   <= cfg_data;
          default: begin
          end
        endcase
      end
      // A new result may replace one that leaves in the same cycle.
      if (cmd.op == OP_LOAD_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_START: begin
          a    <= '0;
          b    <= '0;
          kidx <= '0;
          i    <= '0;
          j    <= '0;
        end
        OP_INIT_WR: begin
          a <= a + BYTE_W'(1);
        end
        OP_KS_RD_B: begin
          b <= b_sum;
        end
        OP_KS_WR_B: begin
          a    <= a + BYTE_W'(1);
          kidx <= (kidx == kidx_last) ? '0 : kidx + KEY_IDX_W'(1);
        end
        OP_GEN_RD_I: begin
          i <= i + BYTE_W'(1);
        end
        OP_GEN_RD_J: begin
          j <= j + ram_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      text <= in_byte;
    end
    unique case (cmd.op)
      OP_KS_RD_B:  hold_first  <= ram_q;
      OP_GEN_RD_J: hold_first  <= ram_q;
      OP_GEN_WR_I: hold_second <= ram_q;
      OP_LOAD_OUT: out_byte    <= ram_q ^ text;
      default: begin
      end
    endcase
  end

  // The permutation is never read at the address written in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("permutation read and write collide");

  a_start_clears_indices: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_START) |=> (i == '0) && (j == '0) && (a == '0) && (b == '0))
    else $error("message start did not clear the indices");

  a_key_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_KS_RD_B) |-> (kidx <= kidx_last))
    else $error("key index beyond key length");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD_OUT) |-> (!out_valid || out_ready))
    else $error("result loaded over a pending result");

endmodule

`default_nettype wire

/* rtl/rc4_stream_cipher_unit.sv */
`default_nettype none

// RC4 byte-stream cipher: every byte taken on the slave stream leaves on the master
// stream XORed with one keystream byte, so the same unit encrypts and decrypts. A byte
// with tuser set first runs the key schedule with the configured key (1 to 16 bytes,
// repeated cyclically) and clears both generator indices. A plain byte is taken in the
// handshake, then passes through the dependent reads of S[i], S[j] and S[S[i]+S[j]] and
// the swap, all going through the one write port and one registered read port of the
// 256-entry permutation memory, and then the load of the result; the next byte is
// accepted only once that load is done. A byte with tuser set first goes through an
// identity fill of the memory and a read-read-write-write swap for each of its 256
// entries. A finished result waits in the output register; the next byte is accepted
// meanwhile, and its result is held back until the register is free. Configuration
// (cfg_index 0: key length, 1: key bytes 0 to 7, 2: key bytes 8 to 15, byte k in bits
// 8k+7 to 8k) is always ready and must be written only while no byte is in flight.
// Bytes sent before the first key schedule produce undefined output.
module rc4_stream_cipher_unit (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [rc4sc_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] text_byte
  input  wire logic                                  s_axis_tuser,  // [0] message_start
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [rc4sc_pkg::BYTE_W-1:0]          m_axis_tdata,  // [7:0] cipher_byte
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rc4sc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [rc4sc_pkg::KEY_WORD_W-1:0]      cfg_data
);

  import rc4sc_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  rc4sc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tready(s_axis_tready),
    .status       (status),
    .cmd          (cmd)
  );

  rc4sc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_byte  (s_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte (m_axis_tdata)
  );

endmodule

`default_nettype wire
